### src/sal_pkg.sv
// Shared constants, types and helper functions for the sorted linked list core.
`default_nettype none

package sal_pkg;

  // Storage geometry.
  localparam int DEPTH    = 16;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LINK_W   = IDX_W + 1;
  localparam int VAL_W    = 32;
  localparam int SLOT_W   = 4;
  localparam int MODE_W   = 2;
  localparam int STATUS_W = 2;

  // A dump emits at most this many items.
  localparam int MAX_OUT  = 16;
  localparam int DUMP_MAX = (MAX_OUT < DEPTH) ? MAX_OUT : DEPTH;
  localparam int CNT_W    = (DUMP_MAX > 1) ? $clog2(DUMP_MAX) : 1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [LINK_W-1:0] link_t;

  // The null link has its top bit set, so it never names a slot.
  localparam link_t NULL_LINK = '1;

  // Input modes.
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DUMP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // One result item handed from the controller to the output register.
  typedef struct packed {
    logic                       load;
    logic [STATUS_W-1:0]        status;
    logic signed [VAL_W-1:0]    value;
    logic [SLOT_W-1:0]          slot;
    logic                       last;
    logic                       is_empty;
    logic                       is_full;
  } res_t;

  function automatic logic link_is_null(input link_t l);
    return l[LINK_W-1];
  endfunction

  // Link held by a slot that was never written since reset or clear.
  function automatic link_t reset_link(input idx_t i);
    link_t r;
    if (i == idx_t'(DEPTH - 1)) begin
      r = NULL_LINK;
    end else begin
      r = link_t'(i) + link_t'(1);
    end
    return r;
  endfunction

  // Slot number as reported, kept to its low four bits.
  function automatic logic [SLOT_W-1:0] slot_of(input idx_t i);
    logic [SLOT_W-1:0] r;
    r = '0;
    for (int b = 0; b < SLOT_W; b++) begin
      if (b < IDX_W) begin
        r[b] = i[b];
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/sal_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module sal_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             we,
  input  wire logic [$clog2(DEPTH)-1:0]         waddr,
  input  wire logic [WIDTH-1:0]                 wdata,
  input  wire logic                             re,
  input  wire logic [$clog2(DEPTH)-1:0]         raddr,
  output logic      [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the data holds while no read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/sal_ctrl.sv
// Sequencer for insert, dump and clear over the linked list in the two RAMs; insert and dump walk it.
`default_nettype none

module sal_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Input item
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [sal_pkg::MODE_W-1:0]        in_mode,
  input  wire logic signed [sal_pkg::VAL_W-1:0]  in_value,
  // Result hand-off
  input  wire logic                              out_free,
  output sal_pkg::res_t                          res,
  // Value RAM
  output logic                                   v_we,
  output sal_pkg::idx_t                          v_waddr,
  output logic [sal_pkg::VAL_W-1:0]              v_wdata,
  output logic                                   v_re,
  output sal_pkg::idx_t                          v_raddr,
  input  wire logic [sal_pkg::VAL_W-1:0]         v_rdata,
  // Link RAM
  output logic                                   l_we,
  output sal_pkg::idx_t                          l_waddr,
  output sal_pkg::link_t                         l_wdata,
  output logic                                   l_re,
  output sal_pkg::idx_t                          l_raddr,
  input  wire sal_pkg::link_t                    l_rdata
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FREE  = 7'b0000010,
    S_WALK  = 7'b0000100,
    S_LINK  = 7'b0001000,
    S_LINK2 = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_DUMP  = 7'b1000000
  } state_t;

  state_t                          state;
  sal_pkg::link_t                  head;
  sal_pkg::link_t                  free_head;
  sal_pkg::link_t                  cur;
  sal_pkg::link_t                  prev;
  sal_pkg::idx_t                   slot_q;
  sal_pkg::idx_t                   rd_idx;
  logic [sal_pkg::DEPTH-1:0]       valid;
  logic [sal_pkg::CNT_W-1:0]       cnt;
  logic signed [sal_pkg::VAL_W-1:0] val_q;
  logic [sal_pkg::STATUS_W-1:0]    res_status;
  logic signed [sal_pkg::VAL_W-1:0] res_value;
  logic [sal_pkg::SLOT_W-1:0]      res_slot;

  logic                            accept;
  sal_pkg::link_t                  link_rd;
  logic                            less;
  logic                            dump_last;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;

  // A slot whose link was never written since reset or clear reads its reset link.
  assign link_rd   = valid[rd_idx] ? l_rdata : sal_pkg::reset_link(rd_idx);
  assign less      = $signed(v_rdata) < val_q;
  assign dump_last = sal_pkg::link_is_null(link_rd) ||
                     (cnt == sal_pkg::CNT_W'(sal_pkg::DUMP_MAX - 1));

  // RAM requests for each state.
  always_comb begin
    v_we    = 1'b0;
    v_waddr = free_head[sal_pkg::IDX_W-1:0];
    v_wdata = in_value;
    v_re    = 1'b0;
    v_raddr = head[sal_pkg::IDX_W-1:0];
    l_we    = 1'b0;
    l_waddr = slot_q;
    l_wdata = cur;
    l_re    = 1'b0;
    l_raddr = head[sal_pkg::IDX_W-1:0];
    case (state)
      S_IDLE: begin
        if (accept && in_mode == sal_pkg::MODE_INSERT &&
            !sal_pkg::link_is_null(free_head)) begin
          v_we    = 1'b1;
          l_re    = 1'b1;
          l_raddr = free_head[sal_pkg::IDX_W-1:0];
        end else if (accept && in_mode == sal_pkg::MODE_DUMP &&
                     !sal_pkg::link_is_null(head)) begin
          v_re = 1'b1;
          l_re = 1'b1;
        end
      end
      S_FREE: begin
        if (!sal_pkg::link_is_null(head)) begin
          v_re = 1'b1;
          l_re = 1'b1;
        end
      end
      S_WALK: begin
        v_raddr = link_rd[sal_pkg::IDX_W-1:0];
        l_raddr = link_rd[sal_pkg::IDX_W-1:0];
        if (less && !sal_pkg::link_is_null(link_rd)) begin
          v_re = 1'b1;
          l_re = 1'b1;
        end
      end
      S_LINK: begin
        l_we = 1'b1;
      end
      S_LINK2: begin
        l_we    = 1'b1;
        l_waddr = prev[sal_pkg::IDX_W-1:0];
        l_wdata = sal_pkg::link_t'(slot_q);
      end
      S_DUMP: begin
        v_raddr = link_rd[sal_pkg::IDX_W-1:0];
        l_raddr = link_rd[sal_pkg::IDX_W-1:0];
        if (out_free && !dump_last) begin
          v_re = 1'b1;
          l_re = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Result item offered to the output register.
  always_comb begin
    res          = '0;
    res.is_empty = sal_pkg::link_is_null(head);
    res.is_full  = sal_pkg::link_is_null(free_head);
    if (state == S_DUMP) begin
      res.load   = out_free;
      res.status = sal_pkg::ST_OK;
      res.value  = $signed(v_rdata);
      res.slot   = sal_pkg::slot_of(cur[sal_pkg::IDX_W-1:0]);
      res.last   = dump_last;
    end else if (state == S_DONE) begin
      res.load   = out_free;
      res.status = res_status;
      res.value  = res_value;
      res.slot   = res_slot;
      res.last   = 1'b1;
    end
  end

  // Sequencer and list pointers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= sal_pkg::NULL_LINK;
      free_head <= '0;
      valid     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (in_mode)
              sal_pkg::MODE_INSERT: begin
                val_q     <= in_value;
                res_value <= in_value;
                if (sal_pkg::link_is_null(free_head)) begin
                  res_status <= sal_pkg::ST_FULL;
                  res_slot   <= '0;
                  state      <= S_DONE;
                end else begin
                  slot_q     <= free_head[sal_pkg::IDX_W-1:0];
                  rd_idx     <= free_head[sal_pkg::IDX_W-1:0];
                  res_status <= sal_pkg::ST_OK;
                  res_slot   <= sal_pkg::slot_of(free_head[sal_pkg::IDX_W-1:0]);
                  state      <= S_FREE;
                end
              end
              sal_pkg::MODE_DUMP: begin
                if (sal_pkg::link_is_null(head)) begin
                  res_status <= sal_pkg::ST_EMPTY;
                  res_value  <= '0;
                  res_slot   <= '0;
                  state      <= S_DONE;
                end else begin
                  cur    <= head;
                  rd_idx <= head[sal_pkg::IDX_W-1:0];
                  cnt    <= '0;
                  state  <= S_DUMP;
                end
              end
              sal_pkg::MODE_CLEAR: begin
                valid      <= '0;
                head       <= sal_pkg::NULL_LINK;
                free_head  <= '0;
                res_status <= sal_pkg::ST_OK;
                res_value  <= '0;
                res_slot   <= '0;
                state      <= S_DONE;
              end
              default: begin
                res_status <= sal_pkg::ST_OK;
                res_value  <= '0;
                res_slot   <= '0;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_FREE: begin
          // Pop the claimed slot off the free list and start at the list head.
          free_head <= link_rd;
          prev      <= sal_pkg::NULL_LINK;
          cur       <= head;
          if (!sal_pkg::link_is_null(head)) begin
            rd_idx <= head[sal_pkg::IDX_W-1:0];
            state  <= S_WALK;
          end else begin
            state <= S_LINK;
          end
        end
        S_WALK: begin
          // Step past nodes smaller than the new value.
          if (less) begin
            prev <= cur;
            cur  <= link_rd;
            if (!sal_pkg::link_is_null(link_rd)) begin
              rd_idx <= link_rd[sal_pkg::IDX_W-1:0];
            end else begin
              state <= S_LINK;
            end
          end else begin
            state <= S_LINK;
          end
        end
        S_LINK: begin
          valid[slot_q] <= 1'b1;
          if (sal_pkg::link_is_null(prev)) begin
            head  <= sal_pkg::link_t'(slot_q);
            state <= S_DONE;
          end else begin
            state <= S_LINK2;
          end
        end
        S_LINK2: begin
          valid[prev[sal_pkg::IDX_W-1:0]] <= 1'b1;
          state                           <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_DUMP: begin
          if (out_free) begin
            if (dump_last) begin
              state <= S_IDLE;
            end else begin
              cur    <= link_rd;
              rd_idx <= link_rd[sal_pkg::IDX_W-1:0];
              cnt    <= cnt + sal_pkg::CNT_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### src/sorted_array_linked_list_core.sv
// Top level of the sorted linked list core: RAMs, sequencer and output register.
//
//   Channel  Direction  Fields
//   s_*      in         s_tuser = mode, s_tdata = value
//   m_*      out        m_tuser = status, m_tdata = out_value/slot/is_empty/is_full,
//                       m_tlast = last
//
// Insert pops a free slot, then walks the list comparing each node (one value
// and link RAM read each), then writes the new node's link and, when it is
// linked behind another node, that node's link too. A full insert, clear or unused
// mode goes straight to the result; a dump emits each node in turn.
// Reset restores an empty list at once; per-slot valid bits stand in for the
// link table's reset contents, so no clearing pass runs.
// The output register holds a result until taken; the sequencer stalls on it.
`default_nettype none

module sorted_array_linked_list_core (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [31:0]                         s_tdata,  // [31:0] value
  input  wire logic [1:0]                          s_tuser,  // [1:0] mode
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [39:0]                              m_tdata,  // [31:0] out_value,
                                                             // [35:32] slot,
                                                             // [36] is_empty,
                                                             // [37] is_full
  output logic [1:0]                               m_tuser,  // [1:0] status
  output logic                                     m_tlast
);

  logic                            out_free;
  sal_pkg::res_t                   res;
  logic                            v_we;
  sal_pkg::idx_t                   v_waddr;
  logic [sal_pkg::VAL_W-1:0]       v_wdata;
  logic                            v_re;
  sal_pkg::idx_t                   v_raddr;
  logic [sal_pkg::VAL_W-1:0]       v_rdata;
  logic                            l_we;
  sal_pkg::idx_t                   l_waddr;
  sal_pkg::link_t                  l_wdata;
  logic                            l_re;
  sal_pkg::idx_t                   l_raddr;
  sal_pkg::link_t                  l_rdata;

  // Stored values.
  sal_ram #(
    .WIDTH (sal_pkg::VAL_W),
    .DEPTH (sal_pkg::DEPTH)
  ) u_value_ram (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (v_wdata),
    .re    (v_re),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  // Next links of both the sorted list and the free list.
  sal_ram #(
    .WIDTH (sal_pkg::LINK_W),
    .DEPTH (sal_pkg::DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (l_we),
    .waddr (l_waddr),
    .wdata (l_wdata),
    .re    (l_re),
    .raddr (l_raddr),
    .rdata (l_rdata)
  );

  sal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_mode  (s_tuser),
    .in_value ($signed(s_tdata)),
    .out_free (out_free),
    .res      (res),
    .v_we     (v_we),
    .v_waddr  (v_waddr),
    .v_wdata  (v_wdata),
    .v_re     (v_re),
    .v_raddr  (v_raddr),
    .v_rdata  (v_rdata),
    .l_we     (l_we),
    .l_waddr  (l_waddr),
    .l_wdata  (l_wdata),
    .l_re     (l_re),
    .l_raddr  (l_raddr),
    .l_rdata  (l_rdata)
  );

  // Output register: a new item may load when empty or being taken.
  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res.load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.load) begin
      m_tdata <= {2'b00, res.is_full, res.is_empty, res.slot, res.value};
      m_tuser <= res.status;
      m_tlast <= res.last;
    end
  end

endmodule

`default_nettype wire
